// ===== rtl/core/steim2_sample_encoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// Steim2 encoder assertion macros
// Shared helpers for the concurrent checks in the encoder core.
// ----------------------------------------------------------------------------
`ifndef STEIM2_SAMPLE_ENCODER_CORE_ASSERT_SVH
`define STEIM2_SAMPLE_ENCODER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define S2ENC_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("s2enc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define S2ENC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("s2enc assertion failed");

`endif

// ===== rtl/core/s2enc_pkg.sv =====
// ----------------------------------------------------------------------------
// Steim2 encoder package
// Types, constants and packing functions shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package s2enc_pkg;

   localparam int unsigned DiffW    = 30;
   localparam int unsigned SampleW  = 32;
   localparam int unsigned WordW    = 32;
   localparam int unsigned FrameW   = 6;
   localparam int unsigned WidxW    = 4;
   localparam int unsigned CountW   = 3;
   localparam int unsigned BufDepth = 7;

   localparam logic [FrameW-1:0] FramesReset = 6'd7;
   localparam logic [WidxW-1:0]  WposReset   = 4'd2;
   localparam logic [WidxW-1:0]  LastWidx    = 4'd15;
   localparam logic [WidxW-1:0]  NibbleWidx  = 4'd0;
   localparam logic [WidxW-1:0]  BeginWidx   = 4'd1;
   localparam logic [WidxW-1:0]  EndWidx     = 4'd2;

   localparam logic signed [SampleW:0] DiffMax = 33'sd536870911;
   localparam logic signed [SampleW:0] DiffMin = -33'sd536870912;

   typedef enum logic {
      ACT_SAMPLE = 1'b0,
      ACT_FLUSH  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_NIBBLE = 2'd1,
      KIND_BEGIN  = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PACK,
      ST_NIBBLE,
      ST_FLUSH_NIB,
      ST_CLOSE
   } state_type;

   typedef logic [BufDepth-1:0][DiffW-1:0]   diff_buf_type;
   typedef logic [BufDepth-1:0][SampleW-1:0] cum_buf_type;

   typedef struct packed {
      action_type         action;
      logic [DiffW-1:0]   diff;
      logic [SampleW-1:0] excess;
      logic [SampleW-1:0] sample;
   } entry_type;

   typedef struct packed {
      logic [WordW-1:0]  word;
      kind_type          kind;
      logic [FrameW-1:0] frame;
      logic [WidxW-1:0]  widx;
      logic              last;
   } result_type;

   function automatic logic [CountW-1:0] fit_of(input logic [DiffW-1:0] d);
      logic signed [DiffW-1:0] s;
      s = signed'(d);
      if (s < -30'sd16384 || s > 30'sd16383) return 3'd1;
      if (s < -30'sd512 || s > 30'sd511) return 3'd2;
      if (s < -30'sd128 || s > 30'sd127) return 3'd3;
      if (s < -30'sd32 || s > 30'sd31) return 3'd4;
      if (s < -30'sd16 || s > 30'sd15) return 3'd5;
      if (s < -30'sd8 || s > 30'sd7) return 3'd6;
      return 3'd7;
   endfunction

   function automatic logic [1:0] nibble_of(input logic [CountW-1:0] n);
      logic [1:0] c;
      case (n) inside
         3'd7, 3'd6, 3'd5: c = 2'd3;
         3'd4:             c = 2'd1;
         default:          c = 2'd2;
      endcase
      return c;
   endfunction

   function automatic logic [WordW-1:0] pack_word(input diff_buf_type b,
                                                  input logic [CountW-1:0] n);
      logic [WordW-1:0] w;
      w = '0;
      case (n)
         3'd7: begin
            w[31:30] = 2'b10;
            for (int i = 0; i < 7; i++) w[27-4*i -: 4] = b[i][3:0];
         end
         3'd6: begin
            w[31:30] = 2'b01;
            for (int i = 0; i < 6; i++) w[29-5*i -: 5] = b[i][4:0];
         end
         3'd5: begin
            for (int i = 0; i < 5; i++) w[29-6*i -: 6] = b[i][5:0];
         end
         3'd4: begin
            for (int i = 0; i < 4; i++) w[31-8*i -: 8] = b[i][7:0];
         end
         3'd3: w = {2'b11, b[0][9:0], b[1][9:0], b[2][9:0]};
         3'd2: w = {2'b10, b[0][14:0], b[1][14:0]};
         default: w = {2'b01, b[0]};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/s2enc_req_if.sv =====
// ----------------------------------------------------------------------------
// Steim2 encoder request channel
// Valid/ready channel carrying one action and one sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface s2enc_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] sample;

   modport source (output valid, output action, output sample, input ready);
   modport sink   (input valid, input action, input sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/s2enc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Steim2 encoder response channel
// Valid/ready channel carrying one record word and its position.
// ----------------------------------------------------------------------------
`default_nettype none

interface s2enc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] word;
   logic [1:0]  word_kind;
   logic [5:0]  frame_index;
   logic [3:0]  word_index;
   logic        record_last;

   modport source (output valid, output word, output word_kind, output frame_index,
                   output word_index, output record_last, input ready);
   modport sink   (input valid, input word, input word_kind, input frame_index,
                   input word_index, input record_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/s2enc_front.sv =====
// ----------------------------------------------------------------------------
// Steim2 encoder front end
// Accepts transactions, forms the clamped first difference and its clamp error.
// ----------------------------------------------------------------------------
`default_nettype none

module s2enc_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   s2enc_req_if.sink                 req_chan,
   output logic                      push_valid,
   input  wire logic                 push_ready,
   output s2enc_pkg::entry_type      push_entry
);

   logic                                hold_valid_ff, hold_valid_in;
   logic                                hold_action_ff;
   logic [s2enc_pkg::SampleW-1:0]       hold_sample_ff;
   logic signed [s2enc_pkg::SampleW:0]  hold_diff_ff;
   logic [s2enc_pkg::SampleW-1:0]       prev_ff, prev_in;
   logic signed [s2enc_pkg::SampleW:0]  diff_raw;
   logic [s2enc_pkg::DiffW-1:0]         diff_clamped;
   logic                                accept;

   assign req_chan.ready = !hold_valid_ff || push_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign diff_raw       = signed'({req_chan.sample[31], req_chan.sample})
                           - signed'({prev_ff[31], prev_ff});

   always_comb begin
      hold_valid_in = hold_valid_ff;
      prev_in       = prev_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         if (req_chan.action == s2enc_pkg::ACT_SAMPLE) begin
            prev_in = req_chan.sample;
         end
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_comb begin
      if (hold_diff_ff > s2enc_pkg::DiffMax) begin
         diff_clamped = s2enc_pkg::DiffMax[s2enc_pkg::DiffW-1:0];
      end else if (hold_diff_ff < s2enc_pkg::DiffMin) begin
         diff_clamped = s2enc_pkg::DiffMin[s2enc_pkg::DiffW-1:0];
      end else begin
         diff_clamped = hold_diff_ff[s2enc_pkg::DiffW-1:0];
      end
   end

   assign push_valid        = hold_valid_ff;
   assign push_entry.action = s2enc_pkg::action_type'(hold_action_ff);
   assign push_entry.diff   = diff_clamped;
   assign push_entry.excess = hold_diff_ff[s2enc_pkg::SampleW-1:0]
                              - {{2{diff_clamped[s2enc_pkg::DiffW-1]}}, diff_clamped};
   assign push_entry.sample = hold_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         prev_ff       <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         prev_ff       <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_action_ff <= req_chan.action;
         hold_sample_ff <= req_chan.sample;
         hold_diff_ff   <= diff_raw;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/s2enc_fifo.sv =====
// ----------------------------------------------------------------------------
// Steim2 encoder decoupling queue
// Two-entry queue between the front end and the packing engine.
// ----------------------------------------------------------------------------
`default_nettype none

module s2enc_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  s2enc_pkg::entry_type      push_entry,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output s2enc_pkg::entry_type      pop_entry
);

   s2enc_pkg::entry_type entry_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/s2enc_back.sv =====
// ----------------------------------------------------------------------------
// Steim2 encoder packing engine
// Buffers differences, packs data words and emits frame and record words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "steim2_sample_encoder_core_assert.svh"

module s2enc_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [5:0]           csr_wr_data,
   input  wire logic                 pop_valid,
   output logic                      pop_ready,
   input  s2enc_pkg::entry_type      pop_entry,
   s2enc_rsp_if.source               rsp_chan
);

   s2enc_pkg::state_type                state_ff, state_in;
   s2enc_pkg::diff_buf_type             diff_ff, diff_in;
   s2enc_pkg::cum_buf_type              cum_ff, cum_in;
   logic [s2enc_pkg::CountW-1:0]        count_ff, count_in;
   logic [s2enc_pkg::SampleW-1:0]       base_ff, base_in;
   logic                                open_ff, open_in;
   logic                                flush_ff, flush_in;
   logic [s2enc_pkg::FrameW-1:0]        frame_ff, frame_in;
   logic [s2enc_pkg::FrameW-1:0]        fpr_ff, fpr_in;
   logic [s2enc_pkg::WidxW-1:0]         wpos_ff, wpos_in;
   logic [s2enc_pkg::WordW-1:0]         code_ff, code_in;
   s2enc_pkg::result_type               res_ff, res_in;
   logic                                res_valid_ff, res_valid_in;
   logic                                emit, out_free;
   logic [s2enc_pkg::CountW-1:0]        fits [s2enc_pkg::BufDepth];
   logic [s2enc_pkg::CountW-1:0]        min_fit, plen;
   logic [s2enc_pkg::WidxW-1:0]         slot;
   logic [4:0]                          shamt;
   logic [s2enc_pkg::FrameW-1:0]        frame_next;

   assign out_free   = !res_valid_ff || rsp_chan.ready;
   assign slot       = wpos_ff + 4'd1;
   assign shamt      = 5'd30 - {slot, 1'b0};
   assign frame_next = frame_ff + 6'd1;
   assign fpr_in     = csr_wr_en ? csr_wr_data : fpr_ff;

   always_comb begin
      logic ok;
      for (int i = 0; i < s2enc_pkg::BufDepth; i++) begin
         fits[i] = s2enc_pkg::fit_of(diff_ff[i]);
      end
      min_fit = 3'd7;
      for (int i = 0; i < s2enc_pkg::BufDepth; i++) begin
         if (3'(i) < count_ff && fits[i] < min_fit) begin
            min_fit = fits[i];
         end
      end
      plen = 3'd1;
      for (int n = 2; n <= s2enc_pkg::BufDepth; n++) begin
         ok = (count_ff >= 3'(n));
         for (int i = 0; i < s2enc_pkg::BufDepth; i++) begin
            if (i < n && fits[i] < 3'(n)) begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            plen = 3'(n);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      diff_in   = diff_ff;
      cum_in    = cum_ff;
      count_in  = count_ff;
      base_in   = base_ff;
      open_in   = open_ff;
      flush_in  = flush_ff;
      frame_in  = frame_ff;
      wpos_in   = wpos_ff;
      code_in   = code_ff;
      pop_ready = 1'b0;
      emit      = 1'b0;
      res_in    = res_ff;
      unique case (state_ff)
         s2enc_pkg::ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               state_in = s2enc_pkg::ST_PACK;
               flush_in = (pop_entry.action == s2enc_pkg::ACT_FLUSH);
               if (pop_entry.action == s2enc_pkg::ACT_SAMPLE) begin
                  for (int i = 0; i < s2enc_pkg::BufDepth; i++) begin
                     if (3'(i) == count_ff) begin
                        diff_in[i] = pop_entry.diff;
                        cum_in[i]  = pop_entry.sample;
                     end else if (3'(i) < count_ff) begin
                        cum_in[i] = cum_ff[i] + pop_entry.excess;
                     end
                  end
                  base_in  = base_ff + pop_entry.excess;
                  count_in = count_ff + 3'd1;
               end
            end
         end
         s2enc_pkg::ST_PACK: begin
            if (count_ff != 3'd0 && (flush_ff || count_ff >= min_fit)) begin
               if (out_free) begin
                  emit = 1'b1;
                  if (!open_ff) begin
                     res_in   = '{cum_ff[0], s2enc_pkg::KIND_BEGIN, '0,
                                  s2enc_pkg::BeginWidx, 1'b0};
                     open_in  = 1'b1;
                     frame_in = '0;
                     code_in  = '0;
                     wpos_in  = s2enc_pkg::WposReset;
                  end else begin
                     res_in  = '{s2enc_pkg::pack_word(diff_ff, plen), s2enc_pkg::KIND_DATA,
                                 frame_ff, slot, 1'b0};
                     code_in = code_ff | ({30'd0, s2enc_pkg::nibble_of(plen)} << shamt);
                     for (int k = 1; k <= s2enc_pkg::BufDepth; k++) begin
                        if (plen == 3'(k)) begin
                           diff_in = diff_ff >> (s2enc_pkg::DiffW * k);
                           cum_in  = cum_ff >> (s2enc_pkg::SampleW * k);
                           base_in = cum_ff[k-1];
                        end
                     end
                     count_in = count_ff - plen;
                     wpos_in  = slot;
                     if (slot == s2enc_pkg::LastWidx) begin
                        state_in = s2enc_pkg::ST_NIBBLE;
                     end
                  end
               end
            end else if (flush_ff && open_ff) begin
               state_in = (wpos_ff != 4'd0) ? s2enc_pkg::ST_FLUSH_NIB : s2enc_pkg::ST_CLOSE;
            end else begin
               state_in = s2enc_pkg::ST_IDLE;
            end
         end
         s2enc_pkg::ST_NIBBLE: begin
            if (out_free) begin
               emit     = 1'b1;
               res_in   = '{code_ff, s2enc_pkg::KIND_NIBBLE, frame_ff,
                            s2enc_pkg::NibbleWidx, 1'b0};
               code_in  = '0;
               wpos_in  = '0;
               frame_in = frame_next;
               state_in = (frame_next == fpr_ff) ? s2enc_pkg::ST_CLOSE : s2enc_pkg::ST_PACK;
            end
         end
         s2enc_pkg::ST_FLUSH_NIB: begin
            if (out_free) begin
               emit     = 1'b1;
               res_in   = '{code_ff, s2enc_pkg::KIND_NIBBLE, frame_ff,
                            s2enc_pkg::NibbleWidx, 1'b0};
               state_in = s2enc_pkg::ST_CLOSE;
            end
         end
         s2enc_pkg::ST_CLOSE: begin
            if (out_free) begin
               emit     = 1'b1;
               res_in   = '{base_ff, s2enc_pkg::KIND_END, '0, s2enc_pkg::EndWidx, 1'b1};
               open_in  = 1'b0;
               state_in = s2enc_pkg::ST_PACK;
            end
         end
         default: begin
            state_in = s2enc_pkg::ST_IDLE;
         end
      endcase
      res_valid_in = emit ? 1'b1 : (rsp_chan.ready ? 1'b0 : res_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= s2enc_pkg::ST_IDLE;
         count_ff     <= '0;
         base_ff      <= '0;
         open_ff      <= 1'b0;
         flush_ff     <= 1'b0;
         frame_ff     <= '0;
         fpr_ff       <= s2enc_pkg::FramesReset;
         wpos_ff      <= s2enc_pkg::WposReset;
         code_ff      <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         base_ff      <= base_in;
         open_ff      <= open_in;
         flush_ff     <= flush_in;
         frame_ff     <= frame_in;
         fpr_ff       <= fpr_in;
         wpos_ff      <= wpos_in;
         code_ff      <= code_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      cum_ff  <= cum_in;
      if (emit) begin
         res_ff <= res_in;
      end
   end

   assign rsp_chan.valid       = res_valid_ff;
   assign rsp_chan.word        = res_ff.word;
   assign rsp_chan.word_kind   = res_ff.kind;
   assign rsp_chan.frame_index = res_ff.frame;
   assign rsp_chan.word_index  = res_ff.widx;
   assign rsp_chan.record_last = res_ff.last;

   `S2ENC_ASSERT_SAME(a_idle_count, clock, reset, state_ff == s2enc_pkg::ST_IDLE,
                      count_ff != 3'(s2enc_pkg::BufDepth))
   `S2ENC_ASSERT_SAME(a_pack_wpos, clock, reset, state_ff == s2enc_pkg::ST_PACK,
                      wpos_ff != s2enc_pkg::LastWidx)
   `S2ENC_ASSERT_NEXT(a_close, clock, reset, state_ff == s2enc_pkg::ST_CLOSE && out_free,
                      !open_ff && res_valid_ff && res_ff.last)
   `S2ENC_ASSERT_NEXT(a_nibble, clock, reset, state_ff == s2enc_pkg::ST_NIBBLE && out_free,
                      wpos_ff == 4'd0 && code_ff == '0)

endmodule

`default_nettype wire

// ===== rtl/core/steim2_sample_encoder_core.sv =====
// ----------------------------------------------------------------------------
// Steim2 sample encoder core
// Turns samples into Steim2 data, nibble, begin and end record words.
//
//   Channel   Direction  Handshake      Carries
//   req_chan  in         valid/ready    action, sample
//   rsp_chan  out        valid/ready    word, word_kind, frame_index,
//                                       word_index, record_last
//   csr_*     in         write enable   frames_per_record
//
// The front end takes one transaction per cycle into a holding register while the queue has room.
// The packing engine loads an item while idle, then emits its words and goes
// back to idle on finding nothing left, taking no new item before that; a flush
// that closes a record then chooses its closing words (nibble and end words).
// A two-entry queue separates the two halves; a stalled output holds the engine.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module steim2_sample_encoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   s2enc_req_if.sink        req_chan,
   s2enc_rsp_if.source      rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [5:0]  csr_wr_data
);

   logic                 push_valid, push_ready;
   logic                 pop_valid, pop_ready;
   s2enc_pkg::entry_type push_entry, pop_entry;

   s2enc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   s2enc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   s2enc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_entry   (pop_entry),
      .rsp_chan    (rsp_chan)
   );

endmodule

`default_nettype wire
